// ----- sv/crc32_frame_deframer_top_assert.svh -----
// assertion macros shared by the deframer modules
`ifndef CRC32_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define CRC32_FRAME_DEFRAMER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CFD_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define CFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/cfd_pkg.sv -----
// shared types, constants and the crc byte update for the frame deframer
package cfd_pkg;

	localparam int BYTE_W     = 8;
	localparam int LEN_W      = 16;
	localparam int CRC_W      = 32;
	localparam int IDX_W      = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int M_TDATA_W  = 40;

	localparam logic [CRC_W-1:0] CRC_INIT   = 32'hFFFF_FFFF;
	localparam logic [CRC_W-1:0] CRC_POLY   = 32'hEDB8_8320;
	localparam logic [CRC_W-1:0] CRC_XOROUT = 32'hFFFF_FFFF;

	localparam logic [BYTE_W-1:0] START_BYTE_RST    = 8'd2;
	localparam logic [LEN_W-1:0]  PAYLOAD_LIMIT_RST = 16'd256;

	localparam logic [IDX_W-1:0] CHECK_LAST_IDX = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_BYTE    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LIMIT = 1'b1;

	// result queue
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	typedef enum logic [2:0] {
		PH_START,
		PH_CMD,
		PH_LEN_LO,
		PH_LEN_HI,
		PH_PAYLOAD,
		PH_CHECK,
		PH_IGNORE
	} phase_t;

	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] pbyte;
		logic              ok;
		logic [BYTE_W-1:0] cmd;
		logic [LEN_W-1:0]  len;
		logic              last;
	} res_t;

	typedef struct packed {
		logic p0;
		logic p1;
		res_t r0;
		res_t r1;
	} oq_push_t;

	// reflected crc-32, one byte, unrolled over its eight bits
	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
			input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc_in ^ {24'h0, b};
		for (int i = 0; i < BYTE_W; i++) begin
			c = (c >> 1) ^ (CRC_POLY & {CRC_W{c[0]}});
		end
		return c;
	endfunction

endpackage

// ----- sv/cfd_core.sv -----
// frame parser: header, payload pass-through, crc check and verdicts
module cfd_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  logic [cfd_pkg::BYTE_W-1:0]    in_byte,
	input  logic                          in_last,
	input  logic [cfd_pkg::BYTE_W-1:0]    start_byte,
	input  logic [cfd_pkg::LEN_W-1:0]     payload_limit,
	output cfd_pkg::oq_push_t             push
);

	`include "crc32_frame_deframer_top_assert.svh"

	cfd_pkg::phase_t                 phase_q, phase_d;
	logic [cfd_pkg::CRC_W-1:0]       crc_q, crc_d, crc_upd;
	logic [cfd_pkg::LEN_W-1:0]       len_q, len_d, len_new, rem_q, rem_d, rem_dec;
	logic [cfd_pkg::BYTE_W-1:0]      cmd_q, cmd_d;
	logic [cfd_pkg::CRC_W-1:0]       chk_q, chk_d, chk_new;
	logic [cfd_pkg::IDX_W-1:0]       idx_q, idx_d;
	cfd_pkg::res_t                   fail_res, pay_res, good_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= cfd_pkg::PH_START;
			crc_q   <= cfd_pkg::CRC_INIT;
			len_q   <= '0;
			rem_q   <= '0;
			cmd_q   <= '0;
			chk_q   <= '0;
			idx_q   <= '0;
		end else if (go) begin
			phase_q <= phase_d;
			crc_q   <= crc_d;
			len_q   <= len_d;
			rem_q   <= rem_d;
			cmd_q   <= cmd_d;
			chk_q   <= chk_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		logic decided;
		logic v0;
		logic v1;
		cfd_pkg::res_t r0;

		crc_upd = cfd_pkg::crc_byte((phase_q == cfd_pkg::PH_START) ? cfd_pkg::CRC_INIT : crc_q,
				in_byte);
		len_new = {in_byte, len_q[cfd_pkg::BYTE_W-1:0]};
		rem_dec = rem_q - 16'd1;
		chk_new = chk_q | ({24'h0, in_byte} << {idx_q, 3'b000});

		fail_res = '0;
		fail_res.kind = 1'b1;
		pay_res = '0;
		pay_res.pbyte = in_byte;
		good_res = '0;
		good_res.kind = 1'b1;
		good_res.ok   = 1'b1;
		good_res.cmd  = cmd_q;
		good_res.len  = len_q;

		phase_d = phase_q;
		crc_d   = crc_q;
		len_d   = len_q;
		rem_d   = rem_q;
		cmd_d   = cmd_q;
		chk_d   = chk_q;
		idx_d   = idx_q;
		decided = 1'b0;
		v0      = 1'b0;
		v1      = 1'b0;
		r0      = fail_res;

		unique case (phase_q)
			cfd_pkg::PH_START: begin
				if (in_byte != start_byte) begin
					v0      = 1'b1;
					decided = 1'b1;
					phase_d = cfd_pkg::PH_IGNORE;
				end else begin
					crc_d   = crc_upd;
					phase_d = cfd_pkg::PH_CMD;
				end
			end
			cfd_pkg::PH_CMD: begin
				cmd_d   = in_byte;
				crc_d   = crc_upd;
				phase_d = cfd_pkg::PH_LEN_LO;
			end
			cfd_pkg::PH_LEN_LO: begin
				len_d   = {8'h0, in_byte};
				crc_d   = crc_upd;
				phase_d = cfd_pkg::PH_LEN_HI;
			end
			cfd_pkg::PH_LEN_HI: begin
				len_d = len_new;
				crc_d = crc_upd;
				if (len_new > payload_limit) begin
					v0      = 1'b1;
					decided = 1'b1;
					phase_d = cfd_pkg::PH_IGNORE;
				end else begin
					rem_d   = len_new;
					phase_d = (len_new == '0) ? cfd_pkg::PH_CHECK : cfd_pkg::PH_PAYLOAD;
				end
			end
			cfd_pkg::PH_PAYLOAD: begin
				v0    = 1'b1;
				r0    = pay_res;
				crc_d = crc_upd;
				rem_d = rem_dec;
				if (rem_dec == '0) begin
					phase_d = cfd_pkg::PH_CHECK;
				end
			end
			cfd_pkg::PH_CHECK: begin
				chk_d = chk_new;
				if (idx_q == cfd_pkg::CHECK_LAST_IDX) begin
					v0      = 1'b1;
					r0      = (chk_new == (crc_q ^ cfd_pkg::CRC_XOROUT)) ? good_res : fail_res;
					decided = 1'b1;
					phase_d = cfd_pkg::PH_IGNORE;
				end else begin
					idx_d = idx_q + 2'd1;
				end
			end
			cfd_pkg::PH_IGNORE: begin
				decided = 1'b1;
			end
			default: begin
				decided = 1'b1;
			end
		endcase

		// buffer end: early end gets a failed verdict, then a fresh frame
		if (in_last) begin
			if (!decided) begin
				if (v0) begin
					v1 = 1'b1;
				end else begin
					v0 = 1'b1;
				end
			end
			phase_d = cfd_pkg::PH_START;
			crc_d   = cfd_pkg::CRC_INIT;
			len_d   = '0;
			rem_d   = '0;
			cmd_d   = '0;
			chk_d   = '0;
			idx_d   = '0;
		end

		push.p0      = go && v0;
		push.p1      = go && v1;
		push.r0      = r0;
		push.r0.last = !v1;
		push.r1      = fail_res;
		push.r1.last = 1'b1;
	end

	`CFD_ASSERT_NEXT(a_clear_on_end, go && in_last,
		phase_q == cfd_pkg::PH_START && crc_q == cfd_pkg::CRC_INIT && idx_q == '0,
		"frame state not cleared after buffer end")
	`CFD_ASSERT(a_pair_is_payload_then_fail, push.p1,
		push.p0 && in_last && !push.r0.kind && push.r1.kind && !push.r1.ok,
		"second result is not a failed verdict after a payload byte")
	`CFD_ASSERT(a_good_only_on_last_check, push.p0 && push.r0.ok,
		phase_q == cfd_pkg::PH_CHECK && idx_q == cfd_pkg::CHECK_LAST_IDX,
		"good verdict outside the final check byte")

endmodule

// ----- sv/cfd_oqueue.sv -----
// result queue: takes up to two results a cycle, hands out one
module cfd_oqueue (
	input  logic              clk,
	input  logic              arst_n,
	input  cfd_pkg::oq_push_t push,
	input  logic              pop,
	output logic              room,
	output logic              head_valid,
	output cfd_pkg::res_t     head
);

	`include "crc32_frame_deframer_top_assert.svh"

	cfd_pkg::res_t                 mem [cfd_pkg::OQ_DEPTH];
	logic [cfd_pkg::OQ_PTR_W-1:0]  wr_ptr_q, rd_ptr_q, wr_ptr_nx;
	logic [cfd_pkg::OQ_CNT_W-1:0]  count_q;
	logic                          do_pop;

	assign wr_ptr_nx  = wr_ptr_q + cfd_pkg::OQ_PTR_W'(1);
	assign head_valid = count_q != '0;
	assign head       = mem[rd_ptr_q];
	assign do_pop     = pop && head_valid;
	// room for a full pair of results
	assign room       = count_q <= cfd_pkg::OQ_CNT_W'(cfd_pkg::OQ_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.p0) begin
			mem[wr_ptr_q] <= push.r0;
		end
		if (push.p1) begin
			mem[wr_ptr_nx] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + cfd_pkg::OQ_PTR_W'(push.p0) + cfd_pkg::OQ_PTR_W'(push.p1);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + cfd_pkg::OQ_PTR_W'(1);
			end
			count_q <= count_q + cfd_pkg::OQ_CNT_W'(push.p0) + cfd_pkg::OQ_CNT_W'(push.p1)
					- cfd_pkg::OQ_CNT_W'(do_pop);
		end
	end

	`CFD_ASSERT(a_push_needs_room, push.p0, room,
		"result pushed without room for a pair")
	`CFD_ASSERT(a_second_needs_first, push.p1, push.p0,
		"second result pushed alone")
	`CFD_ASSERT(a_count_bound, 1'b1, count_q <= cfd_pkg::OQ_CNT_W'(cfd_pkg::OQ_DEPTH),
		"result queue count beyond depth")

endmodule

// ----- sv/crc32_frame_deframer_top.sv -----
// frame deframer top level: input register, parser, result queue, config registers
// a byte accepted into the input register is parsed once the queue has room, and its results
// are written into the result queue, whose head drives m_tvalid
// throughput: one input byte per cycle while the queue has room; a byte that ends a frame
// early in the payload gives two results, which leave one at a time via the four-entry queue
// the input register is released only while the queue has room for two results
// reset (arst_n low, asynchronous): parser back to expecting a start byte, queue empty,
// start_byte = 2 and payload_limit = 256
module crc32_frame_deframer_top (
	input  logic                                clk,
	input  logic                                arst_n,
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [cfd_pkg::BYTE_W-1:0]          s_tdata,   // [7:0] rx_byte
	input  logic                                s_tlast,   // buffer_end
	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [7:0] payload_byte, [8] frame_ok, [16:9] command, [32:17] payload_length,
	// [39:33] zero
	output logic [cfd_pkg::M_TDATA_W-1:0]       m_tdata,
	output logic                                m_tuser,   // item_kind
	output logic                                m_tlast,   // run_last
	// configuration writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [cfd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cfd_pkg::CFG_DATA_W-1:0]      cfg_data
);

	logic                            valid_s1;
	logic [cfd_pkg::BYTE_W-1:0]      byte_s1;
	logic                            last_s1;
	logic                            go;
	logic                            room;
	logic [cfd_pkg::BYTE_W-1:0]      start_byte_q;
	logic [cfd_pkg::LEN_W-1:0]       payload_limit_q;
	cfd_pkg::oq_push_t               push;
	cfd_pkg::res_t                   head;

	// config registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q    <= cfd_pkg::START_BYTE_RST;
			payload_limit_q <= cfd_pkg::PAYLOAD_LIMIT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				cfd_pkg::REG_START_BYTE:    start_byte_q    <= cfg_data[cfd_pkg::BYTE_W-1:0];
				cfd_pkg::REG_PAYLOAD_LIMIT: payload_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register: the byte is parsed when the queue can take its results
	assign go       = valid_s1 && room;
	assign s_tready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	cfd_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.go            (go),
		.in_byte       (byte_s1),
		.in_last       (last_s1),
		.start_byte    (start_byte_q),
		.payload_limit (payload_limit_q),
		.push          (push)
	);

	cfd_oqueue u_oqueue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (m_tready),
		.room       (room),
		.head_valid (m_tvalid),
		.head       (head)
	);

	// result packing, first field in the low bits
	assign m_tdata = {7'h0, head.len, head.cmd, head.ok, head.pbyte};
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

endmodule
